/* rtl/core/chip8_register_alu_branch_execute_unit_macros.svh */
// ----------------------------------------------------------------------------
// chip8 execute unit assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CHIP8_REGISTER_ALU_BRANCH_EXECUTE_UNIT_MACROS_SVH
`define CHIP8_REGISTER_ALU_BRANCH_EXECUTE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define C8_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define C8_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define C8_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define C8_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

/* rtl/core/c8exe_pkg.sv */
// ----------------------------------------------------------------------------
// c8exe_pkg
// shared types, opcode codes and sizes of the chip8 execute unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c8exe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SC_W        = $clog2(STACK_DEPTH + 1);
    localparam int SP_W        = $clog2(STACK_DEPTH);

    localparam int NUM_REGS = 16;
    localparam int RA_W     = $clog2(NUM_REGS);

    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    localparam int RQ_DEPTH = 2;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    localparam logic [11:0] PC_RESET = 12'h200;
    localparam logic [11:0] PC_STEP  = 12'd2;
    localparam logic [11:0] PC_SKIP  = 12'd4;
    localparam logic [RA_W-1:0] REG_V0 = RA_W'(0);
    localparam logic [RA_W-1:0] REG_VF = RA_W'(NUM_REGS - 1);

    // item kinds
    localparam logic OP_EXEC = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // top nibble opcode groups
    localparam logic [3:0] OPC_SYS  = 4'h0;
    localparam logic [3:0] OPC_JP   = 4'h1;
    localparam logic [3:0] OPC_CALL = 4'h2;
    localparam logic [3:0] OPC_SE   = 4'h3;
    localparam logic [3:0] OPC_SNE  = 4'h4;
    localparam logic [3:0] OPC_SER  = 4'h5;
    localparam logic [3:0] OPC_LD   = 4'h6;
    localparam logic [3:0] OPC_ADD  = 4'h7;
    localparam logic [3:0] OPC_ALU  = 4'h8;
    localparam logic [3:0] OPC_SNER = 4'h9;
    localparam logic [3:0] OPC_LDI  = 4'hA;
    localparam logic [3:0] OPC_JPV0 = 4'hB;
    localparam logic [3:0] OPC_RND  = 4'hC;
    localparam logic [3:0] OPC_MISC = 4'hF;

    localparam logic [15:0] INS_RET = 16'h00EE;
    localparam logic [3:0]  N_ZERO  = 4'h0;

    // 8xy_ sub-operations
    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Fx__ sub-operations
    localparam logic [7:0] FX_GET_DT = 8'h07;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_SET_ST = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_LD_I_V = 8'h29;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNSUP     = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        K_TICK,
        K_UNSUP,
        K_RET,
        K_JP,
        K_CALL,
        K_SE_K,
        K_SNE_K,
        K_SE_R,
        K_SNE_R,
        K_LD_K,
        K_ADD_K,
        K_ALU,
        K_LD_I,
        K_JP_V0,
        K_GET_DT,
        K_SET_DT,
        K_SET_ST,
        K_ADD_I,
        K_LD_I_V
    } kind_t;

    // decoded instruction handed from front to back
    typedef struct packed {
        kind_t            kind;
        logic [RA_W-1:0]  x;
        logic [RA_W-1:0]  y;
        logic [3:0]       alu;
        logic [7:0]       imm;
        logic [11:0]      nnn;
    } dec_t;

    typedef struct packed {
        logic [11:0]     next_pc;
        logic [15:0]     index_value;
        logic            dest_written;
        logic [RA_W-1:0] dest_reg;
        logic [7:0]      dest_value;
        logic            flag_written;
        logic [7:0]      flag_value;
        logic            sound_active;
        status_t         status;
    } res_t;

endpackage

`default_nettype wire

/* rtl/core/chip8_register_alu_branch_execute_unit.sv */
// ----------------------------------------------------------------------------
// chip8_register_alu_branch_execute_unit
// chip8 register, alu and branch execute unit with queue-style ports
// ----------------------------------------------------------------------------
// usage:
//   input side is a queue write port: drive op, instruction, random_byte and
//   raise push; the transaction is taken on a clock edge with full low.
//   op 0 executes the instruction word, op 1 applies one timer tick.
//   result side is a queue read port: while empty is low the oldest result
//   sits on the result ports; raise pop to take it.
//   every input transaction gives exactly one result transaction.
// path: an item passes the decode queue, the execute register and the
//   result queue in that order before its result can be popped.
// throughput: one instruction per cycle while the result queue has room;
//   register-file reads are registered with a write bypass so that
//   dependent instructions still issue back to back.
// reset: registers clear to zero, pc to 0x200, stack empty, both queues
//   empty; the return stack contents stay undefined until pushed.
// stall: when pop is held low the two-entry result queue fills, execute
//   halts, then the two-entry decode queue fills and full rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chip8_register_alu_branch_execute_unit
    import c8exe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        op,
    input  wire logic [15:0] instruction,
    input  wire logic [7:0]  random_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [11:0]      next_pc,
    output logic [15:0]      index_value,
    output logic             dest_written,
    output logic [3:0]       dest_reg,
    output logic [7:0]       dest_value,
    output logic             flag_written,
    output logic [7:0]       flag_value,
    output logic             sound_active,
    output logic [1:0]       status
);

    dec_t fq_item;
    logic fq_empty;
    logic fq_pop;
    res_t res_head;

    c8exe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .instruction (instruction),
        .random_byte (random_byte),
        .fq_item     (fq_item),
        .fq_empty    (fq_empty),
        .fq_pop      (fq_pop)
    );

    c8exe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .fq_item  (fq_item),
        .fq_empty (fq_empty),
        .fq_pop   (fq_pop),
        .pop      (pop),
        .empty    (empty),
        .res_head (res_head)
    );

    assign next_pc      = res_head.next_pc;
    assign index_value  = res_head.index_value;
    assign dest_written = res_head.dest_written;
    assign dest_reg     = res_head.dest_reg;
    assign dest_value   = res_head.dest_value;
    assign flag_written = res_head.flag_written;
    assign flag_value   = res_head.flag_value;
    assign sound_active = res_head.sound_active;
    assign status       = res_head.status;

endmodule

`default_nettype wire

/* rtl/core/c8exe_front.sv */
// ----------------------------------------------------------------------------
// c8exe_front
// accepts items, decodes them into kinds and queues them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c8exe_front
    import c8exe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        op,
    input  wire logic [15:0] instruction,
    input  wire logic [7:0]  random_byte,
    output dec_t             fq_item,
    output logic             fq_empty,
    input  wire logic        fq_pop
);

    dec_t              dec;
    dec_t              fq_mem_reg [FQ_DEPTH];
    logic [FQ_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FQ_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FQ_CW-1:0]  cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        dec.kind = K_UNSUP;
        dec.x    = instruction[11:8];
        dec.y    = instruction[7:4];
        dec.alu  = instruction[3:0];
        dec.imm  = instruction[7:0];
        dec.nnn  = instruction[11:0];
        if (op == OP_TICK)
        begin
            dec.kind = K_TICK;
        end
        else
        begin
            unique case (instruction[15:12])
                OPC_SYS:  dec.kind = (instruction == INS_RET) ? K_RET : K_UNSUP;
                OPC_JP:   dec.kind = K_JP;
                OPC_CALL: dec.kind = K_CALL;
                OPC_SE:   dec.kind = K_SE_K;
                OPC_SNE:  dec.kind = K_SNE_K;
                OPC_SER:  dec.kind = (instruction[3:0] == N_ZERO) ? K_SE_R : K_UNSUP;
                OPC_LD:   dec.kind = K_LD_K;
                OPC_ADD:  dec.kind = K_ADD_K;
                OPC_ALU:
                begin
                    unique case (instruction[3:0]) inside
                        ALU_LD, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                        ALU_SHR, ALU_SUBN, ALU_SHL: dec.kind = K_ALU;
                        default:                    dec.kind = K_UNSUP;
                    endcase
                end
                OPC_SNER: dec.kind = (instruction[3:0] == N_ZERO) ? K_SNE_R : K_UNSUP;
                OPC_LDI:  dec.kind = K_LD_I;
                OPC_JPV0: dec.kind = K_JP_V0;
                OPC_RND:
                begin
                    // random AND folds into a plain immediate load
                    dec.kind = K_LD_K;
                    dec.imm  = random_byte & instruction[7:0];
                end
                OPC_MISC:
                begin
                    unique case (instruction[7:0])
                        FX_GET_DT: dec.kind = K_GET_DT;
                        FX_SET_DT: dec.kind = K_SET_DT;
                        FX_SET_ST: dec.kind = K_SET_ST;
                        FX_ADD_I:  dec.kind = K_ADD_I;
                        FX_LD_I_V: dec.kind = K_LD_I_V;
                        default:   dec.kind = K_UNSUP;
                    endcase
                end
                default:  dec.kind = K_UNSUP;
            endcase
        end
    end

    assign full     = (cnt_reg == FQ_CW'(FQ_DEPTH));
    assign fq_empty = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = fq_pop && !fq_empty;
    assign fq_item  = fq_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fq_mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/c8exe_back.sv */
// ----------------------------------------------------------------------------
// c8exe_back
// executes decoded items against the machine state and queues the results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "chip8_register_alu_branch_execute_unit_macros.svh"

module c8exe_back
    import c8exe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  dec_t      fq_item,
    input  wire logic fq_empty,
    output logic      fq_pop,
    input  wire logic pop,
    output logic      empty,
    output res_t      res_head
);

    // register file, vf and v0 kept in flops beside it
    logic [7:0]          rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic                rf_we;
    logic [RA_W-1:0]     rf_wa;
    logic [7:0]          rf_wd;
    logic [7:0]          vf_reg, vf_next;
    logic [7:0]          v0_reg;

    // execute stage
    logic                e_valid_reg;
    dec_t                e_item_reg;
    logic [7:0]          rdx_raw_reg, rdy_raw_reg;
    logic                rdx_ok_reg, rdy_ok_reg;
    logic                byp_x_reg, byp_y_reg;
    logic [7:0]          byp_data_reg;
    logic                e_load;
    logic                e_fire;
    logic [7:0]          vx_file, vy_file, vx, vy;

    // architectural state
    logic [11:0]         pc_reg, pc_next;
    logic [15:0]         idx_reg, idx_next;
    logic [7:0]          dt_reg, dt_next;
    logic [7:0]          st_reg, st_next;
    logic [SC_W-1:0]     sc_reg, sc_next;
    logic [11:0]         stack_mem_reg [STACK_DEPTH];
    logic                stk_push;
    logic [SC_W-1:0]     sc_dec;
    logic [11:0]         pc_plus2, pc_plus4;
    logic [8:0]          sum9;
    logic                wr, fw;
    logic [7:0]          wres, flag;
    status_t             status;
    res_t                res;

    // result queue
    res_t                rq_mem_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]    rq_wr_ptr_reg, rq_rd_ptr_reg;
    logic [RQ_CW-1:0]    rq_cnt_reg, rq_cnt_next;
    logic                rq_pop;
    logic                rq_space;

    assign rq_pop   = pop && !empty;
    assign empty    = (rq_cnt_reg == '0);
    assign rq_space = (rq_cnt_reg != RQ_CW'(RQ_DEPTH)) || rq_pop;
    assign e_fire   = e_valid_reg && rq_space;
    assign e_load   = !fq_empty && (!e_valid_reg || e_fire);
    assign fq_pop   = e_load;
    assign res_head = rq_mem_reg[rq_rd_ptr_reg];

    // operands: same-edge write bypass, then valid bit, then vf override
    assign vx_file = byp_x_reg ? byp_data_reg : (rdx_ok_reg ? rdx_raw_reg : 8'h00);
    assign vy_file = byp_y_reg ? byp_data_reg : (rdy_ok_reg ? rdy_raw_reg : 8'h00);
    assign vx      = (e_item_reg.x == REG_VF) ? vf_reg : vx_file;
    assign vy      = (e_item_reg.y == REG_VF) ? vf_reg : vy_file;

    assign pc_plus2 = pc_reg + PC_STEP;
    assign pc_plus4 = pc_reg + PC_SKIP;
    assign sum9     = {1'b0, vx} + {1'b0, vy};
    assign sc_dec   = sc_reg - 1'b1;

    always_comb
    begin
        pc_next  = pc_plus2;
        idx_next = idx_reg;
        dt_next  = dt_reg;
        st_next  = st_reg;
        sc_next  = sc_reg;
        stk_push = 1'b0;
        wr       = 1'b0;
        fw       = 1'b0;
        wres     = 8'h00;
        flag     = 8'h00;
        status   = ST_OK;
        case (e_item_reg.kind)
            K_TICK:
            begin
                pc_next = pc_reg;
                if (dt_reg != 8'h00)
                begin
                    dt_next = dt_reg - 1'b1;
                end
                if (st_reg != 8'h00)
                begin
                    st_next = st_reg - 1'b1;
                end
            end
            K_RET:
            begin
                if (sc_reg == '0)
                begin
                    status = ST_UNDERFLOW;
                end
                else
                begin
                    sc_next = sc_dec;
                    pc_next = stack_mem_reg[sc_dec[SP_W-1:0]];
                end
            end
            K_JP:    pc_next = e_item_reg.nnn;
            K_CALL:
            begin
                if (sc_reg == SC_W'(STACK_DEPTH))
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    stk_push = 1'b1;
                    sc_next  = sc_reg + 1'b1;
                    pc_next  = e_item_reg.nnn;
                end
            end
            K_SE_K:  pc_next = (vx == e_item_reg.imm) ? pc_plus4 : pc_plus2;
            K_SNE_K: pc_next = (vx != e_item_reg.imm) ? pc_plus4 : pc_plus2;
            K_SE_R:  pc_next = (vx == vy) ? pc_plus4 : pc_plus2;
            K_SNE_R: pc_next = (vx != vy) ? pc_plus4 : pc_plus2;
            K_LD_K:
            begin
                wr   = 1'b1;
                wres = e_item_reg.imm;
            end
            K_ADD_K:
            begin
                wr   = 1'b1;
                wres = vx + e_item_reg.imm;
            end
            K_ALU:
            begin
                wr = 1'b1;
                case (e_item_reg.alu)
                    ALU_LD:  wres = vy;
                    ALU_OR:  wres = vx | vy;
                    ALU_AND: wres = vx & vy;
                    ALU_XOR: wres = vx ^ vy;
                    ALU_ADD:
                    begin
                        fw   = 1'b1;
                        wres = sum9[7:0];
                        flag = {7'b0, sum9[8]};
                    end
                    ALU_SUB:
                    begin
                        fw   = 1'b1;
                        wres = vx - vy;
                        flag = {7'b0, (vx >= vy)};
                    end
                    ALU_SHR:
                    begin
                        fw   = 1'b1;
                        wres = {1'b0, vx[7:1]};
                        flag = {7'b0, vx[0]};
                    end
                    ALU_SUBN:
                    begin
                        fw   = 1'b1;
                        wres = vy - vx;
                        flag = {7'b0, (vy >= vx)};
                    end
                    ALU_SHL:
                    begin
                        fw   = 1'b1;
                        wres = {vx[6:0], 1'b0};
                        flag = {7'b0, vx[7]};
                    end
                    default: wres = vy;
                endcase
            end
            K_LD_I:   idx_next = {4'h0, e_item_reg.nnn};
            K_JP_V0:  pc_next  = e_item_reg.nnn + {4'h0, v0_reg};
            K_GET_DT:
            begin
                wr   = 1'b1;
                wres = dt_reg;
            end
            K_SET_DT: dt_next  = vx;
            K_SET_ST: st_next  = vx;
            K_ADD_I:  idx_next = idx_reg + {8'h00, vx};
            K_LD_I_V: idx_next = {8'h00, vx};
            default:  status   = ST_UNSUP;
        endcase
    end

    // flag lands after the result, so it wins when x is vf
    always_comb
    begin
        vf_next = vf_reg;
        if (fw)
        begin
            vf_next = flag;
        end
        else if (wr && (e_item_reg.x == REG_VF))
        begin
            vf_next = wres;
        end
    end

    assign rf_we = e_fire && wr && (e_item_reg.x != REG_VF);
    assign rf_wa = e_item_reg.x;
    assign rf_wd = wres;

    always_comb
    begin
        res.next_pc      = pc_next;
        res.index_value  = idx_next;
        res.dest_written = wr;
        res.dest_reg     = wr ? e_item_reg.x : '0;
        // with x at vf the register ends up holding the flag if fw, else wres
        res.dest_value   = wr ? ((e_item_reg.x == REG_VF) ? vf_next : wres) : 8'h00;
        res.flag_written = fw;
        res.flag_value   = vf_next;
        res.sound_active = (st_next != 8'h00);
        res.status       = status;
    end

    always_comb
    begin
        rq_cnt_next = rq_cnt_reg;
        if (e_fire && !rq_pop)
        begin
            rq_cnt_next = rq_cnt_reg + 1'b1;
        end
        else if (rq_pop && !e_fire)
        begin
            rq_cnt_next = rq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            rf_valid_reg  <= '0;
            vf_reg        <= 8'h00;
            v0_reg        <= 8'h00;
            pc_reg        <= PC_RESET;
            idx_reg       <= 16'h0000;
            dt_reg        <= 8'h00;
            st_reg        <= 8'h00;
            sc_reg        <= '0;
            rq_wr_ptr_reg <= '0;
            rq_rd_ptr_reg <= '0;
            rq_cnt_reg    <= '0;
            rdx_ok_reg    <= 1'b0;
            rdy_ok_reg    <= 1'b0;
            byp_x_reg     <= 1'b0;
            byp_y_reg     <= 1'b0;
        end
        else
        begin
            if (e_load)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end
            if (e_load)
            begin
                rdx_ok_reg <= rf_valid_reg[fq_item.x];
                rdy_ok_reg <= rf_valid_reg[fq_item.y];
                byp_x_reg  <= rf_we && (rf_wa == fq_item.x);
                byp_y_reg  <= rf_we && (rf_wa == fq_item.y);
            end
            if (rf_we)
            begin
                rf_valid_reg[rf_wa] <= 1'b1;
                if (rf_wa == REG_V0)
                begin
                    v0_reg <= rf_wd;
                end
            end
            if (e_fire)
            begin
                vf_reg  <= vf_next;
                pc_reg  <= pc_next;
                idx_reg <= idx_next;
                dt_reg  <= dt_next;
                st_reg  <= st_next;
                sc_reg  <= sc_next;
                rq_wr_ptr_reg <= (rq_wr_ptr_reg == RQ_AW'(RQ_DEPTH - 1)) ? '0
                                 : rq_wr_ptr_reg + 1'b1;
            end
            if (rq_pop)
            begin
                rq_rd_ptr_reg <= (rq_rd_ptr_reg == RQ_AW'(RQ_DEPTH - 1)) ? '0
                                 : rq_rd_ptr_reg + 1'b1;
            end
            rq_cnt_reg <= rq_cnt_next;
        end
    end

    // register file memory, registered read ports at x and y
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_wa] <= rf_wd;
        end
        if (e_load)
        begin
            rdx_raw_reg  <= rf_mem[fq_item.x];
            rdy_raw_reg  <= rf_mem[fq_item.y];
            byp_data_reg <= rf_wd;
            e_item_reg   <= fq_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_fire && stk_push)
        begin
            stack_mem_reg[sc_reg[SP_W-1:0]] <= pc_plus2;
        end
        if (e_fire)
        begin
            rq_mem_reg[rq_wr_ptr_reg] <= res;
        end
    end

    `C8_ASSERT_IMPLIES(a_stack_bound, clk, rst_n, 1'b1, sc_reg <= SC_W'(STACK_DEPTH))
    `C8_ASSERT_IMPLIES(a_rq_block, clk, rst_n, (rq_cnt_reg == RQ_CW'(RQ_DEPTH)) && !rq_pop, !e_fire)
    `C8_ASSERT_NEXT(a_tick_pc, clk, rst_n, e_fire && (e_item_reg.kind == K_TICK), $stable(pc_reg))
    `C8_ASSERT_NEXT(a_ovf_sc, clk, rst_n, e_fire && (status == ST_OVERFLOW), $stable(sc_reg))

endmodule

`default_nettype wire
